@@ hw/rtl/spq_pkg.sv @@
// shared types and constants of the sorted priority queue
package spq_pkg;

  // default number of entries the queue holds
  localparam int unsigned CAPACITY = 16;

  localparam int unsigned TagW = 16;
  localparam int unsigned PriW = 8;
  localparam int unsigned OccW = 5;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_OVERFLOW = 2'd1,
    STATUS_EMPTY    = 2'd2
  } status_e;

  // one input transaction
  typedef struct packed {
    op_e             op;
    logic [TagW-1:0] item_tag;
    logic [PriW-1:0] item_priority;
  } in_item_t;

  // one result transaction
  typedef struct packed {
    status_e         status;
    logic [TagW-1:0] head_tag;
    logic [PriW-1:0] head_priority;
    logic [OccW-1:0] occupancy;
  } out_item_t;

  // contents of one queue slot
  typedef struct packed {
    logic [TagW-1:0] tag;
    logic [PriW-1:0] prio;
  } entry_t;

  // broadcast control seen by every cell
  typedef struct packed {
    logic   insert;
    logic   remove;
    entry_t new_entry;
  } cell_ctrl_t;

endpackage

@@ hw/rtl/spq_cell.sv @@
// one slot of the sorted chain: holds an entry and trades it with its neighbours
module spq_cell (
  input  logic               clk_i,
  input  logic               live_i,
  input  spq_pkg::cell_ctrl_t ctrl_i,
  input  spq_pkg::entry_t    prev_entry_i,
  input  logic               prev_gt_i,
  input  spq_pkg::entry_t    next_entry_i,
  output spq_pkg::entry_t    entry_o,
  output logic               gt_o
);
  import spq_pkg::*;

  entry_t entry_q, entry_d;

  // an empty slot counts as larger than anything, so the new entry lands there
  assign gt_o = !live_i || (entry_q.prio > ctrl_i.new_entry.prio);

  // insert shifts the larger tail back by one, remove pulls everything forward
  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.insert) begin
      if (gt_o) begin
        entry_d = prev_gt_i ? prev_entry_i : ctrl_i.new_entry;
      end
    end else if (ctrl_i.remove) begin
      entry_d = next_entry_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

@@ hw/rtl/sorted_priority_queue_unit.sv @@
// Sorted priority queue of up to Capacity entries (16-bit tag, 8-bit priority) kept as a
// chain of slot cells, head in cell 0; lower priority values leave first and equal
// priorities leave in arrival order. All cells of the chain compare against the new
// priority in parallel, so one insert or remove transaction is accepted per cycle while
// the input is not stalled, and its result appears in the output register in the next
// cycle. Input stall is raised only while that register holds a result the receiver
// stalls. Storage needs no clearing after reset.
module sorted_priority_queue_unit #(
  parameter int unsigned Capacity = spq_pkg::CAPACITY
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  spq_pkg::in_item_t in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output spq_pkg::out_item_t out_data_o
);
  import spq_pkg::*;

  localparam int unsigned CntW = $clog2(Capacity + 1);

  logic [CntW-1:0] count_q, count_d;
  logic            out_valid_q;
  out_item_t       out_data_q, out_data_d;

  logic       in_accept, full, empty, insert_ok, remove_ok;
  cell_ctrl_t ctrl;
  entry_t     entries [Capacity];
  logic       gts     [Capacity];

  // handshake and queue condition
  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign full       = (count_q == CntW'(Capacity));
  assign empty      = (count_q == '0);
  assign insert_ok  = in_accept && (in_data_i.op == OP_INSERT) && !full;
  assign remove_ok  = in_accept && (in_data_i.op == OP_REMOVE) && !empty;

  // broadcast control to the cell chain
  assign ctrl.insert         = insert_ok;
  assign ctrl.remove         = remove_ok;
  assign ctrl.new_entry.tag  = in_data_i.item_tag;
  assign ctrl.new_entry.prio = in_data_i.item_priority;

  // chain of slot cells
  for (genvar i = 0; i < Capacity; i++) begin : g_cell
    entry_t prev_entry, next_entry;
    logic   prev_gt;
    if (i == 0) begin : g_head
      assign prev_entry = ctrl.new_entry;
      assign prev_gt    = 1'b0;
    end else begin : g_body
      assign prev_entry = entries[i-1];
      assign prev_gt    = gts[i-1];
    end
    if (i == Capacity - 1) begin : g_tail
      assign next_entry = entries[i];
    end else begin : g_mid
      assign next_entry = entries[i+1];
    end
    spq_cell u_cell (
      .clk_i        (clk_i),
      .live_i       (CntW'(i) < count_q),
      .ctrl_i       (ctrl),
      .prev_entry_i (prev_entry),
      .prev_gt_i    (prev_gt),
      .next_entry_i (next_entry),
      .entry_o      (entries[i]),
      .gt_o         (gts[i])
    );
  end

  // entry count
  always_comb begin
    count_d = count_q;
    if (insert_ok) begin
      count_d = count_q + CntW'(1);
    end else if (remove_ok) begin
      count_d = count_q - CntW'(1);
    end
  end

  // result of the accepted transaction
  always_comb begin
    out_data_d               = '0;
    out_data_d.status        = STATUS_OK;
    out_data_d.occupancy     = OccW'(count_d);
    if (in_data_i.op == OP_INSERT) begin
      if (full) begin
        out_data_d.status = STATUS_OVERFLOW;
      end
    end else if (empty) begin
      out_data_d.status = STATUS_EMPTY;
    end else begin
      out_data_d.head_tag      = entries[0].tag;
      out_data_d.head_priority = entries[0].prio;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (in_accept) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload register
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Capacity))
    else $error("entry count above capacity");

  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    insert_ok |=> count_q == $past(count_q) + CntW'(1))
    else $error("insert did not grow the queue");

  a_empty_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_data_q.status == STATUS_EMPTY) |->
      (out_data_q.occupancy == '0) && (out_data_q.head_tag == '0))
    else $error("empty result carries data");

  a_head_sorted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q >= CntW'(2)) |-> entries[0].prio <= entries[1].prio)
    else $error("head not the lowest priority");

endmodule

@@ test/spq_scoreboard_pkg.sv @@
// scoreboard class predicting and checking the sorted priority queue
`timescale 1ns / 1ps

package spq_scoreboard_pkg;
  import spq_pkg::*;

  // one live queue slot as the predictor keeps it
  typedef struct packed {
    logic [TagW-1:0] tag;
    logic [PriW-1:0] prio;
  } shadow_slot_t;

  class queue_scoreboard;
    shadow_slot_t shadow_slots[$];    // head first
    out_item_t    pending_results[$]; // oldest first
    int unsigned  slot_limit;
    int unsigned  error_count;

    function new(int unsigned slots);
      slot_limit  = slots;
      error_count = 0;
    endfunction

    // apply an accepted transaction to the shadow queue and queue its result
    function void accept_request(in_item_t req);
      out_item_t    res;
      shadow_slot_t slot;
      int unsigned  pos;
      res        = '0;
      res.status = STATUS_OK;
      if (req.op == OP_INSERT) begin
        if (shadow_slots.size() >= slot_limit) begin
          res.status = STATUS_OVERFLOW;
        end else begin
          // new entry goes behind every entry of equal or lower value
          pos = shadow_slots.size();
          while (pos > 0 && shadow_slots[pos-1].prio > req.item_priority) pos--;
          slot.tag  = req.item_tag;
          slot.prio = req.item_priority;
          shadow_slots.insert(pos, slot);
        end
      end else if (shadow_slots.size() == 0) begin
        res.status = STATUS_EMPTY;
      end else begin
        slot              = shadow_slots.pop_front();
        res.head_tag      = slot.tag;
        res.head_priority = slot.prio;
      end
      res.occupancy = OccW'(shadow_slots.size());
      pending_results.push_back(res);
    endfunction

    function void compare_field(string field, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s: expected %0d, actual %0d", field, want, got);
        error_count++;
      end
    endfunction

    // compare a delivered result with the oldest prediction
    function void check_result(out_item_t got);
      out_item_t want;
      if (pending_results.size() == 0) begin
        $error("result with no transaction pending: status %0d tag %0d priority %0d",
               got.status, got.head_tag, got.head_priority);
        error_count++;
        return;
      end
      want = pending_results.pop_front();
      if ($isunknown(got)) begin
        $error("result: expected %h, actual %h", want, got);
        error_count++;
        return;
      end
      compare_field("status", want.status, got.status);
      compare_field("head_tag", want.head_tag, got.head_tag);
      compare_field("head_priority", want.head_priority, got.head_priority);
      compare_field("occupancy", want.occupancy, got.occupancy);
    endfunction
  endclass

endpackage

@@ test/tb_top.sv @@
// top-level testbench of the sorted priority queue unit
`timescale 1ns / 1ps

module tb_top;
  import spq_pkg::*;
  import spq_scoreboard_pkg::*;

  localparam int unsigned QuietLimit = 2000;
  localparam int unsigned BurstCount = 10;
  localparam int unsigned BurstLen   = 34;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;

  queue_scoreboard scoreboard;

  sorted_priority_queue_unit DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // monitor both channels, then draw the next receiver stall
  always @(posedge clk_i) begin
    if (in_valid && !in_stall) scoreboard.accept_request(in_data);
    if (out_valid && !out_stall) scoreboard.check_result(out_data);
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // watchdog on cycles without any transaction
  initial begin : watchdog
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < QuietLimit) begin
      @(posedge clk_i);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("sorted_priority_queue_unit regression: fail");
    $finish;
  end

  function automatic in_item_t make_item(op_e op, int unsigned tag, int unsigned prio);
    in_item_t item;
    item.op            = op;
    item.item_tag      = TagW'(tag);
    item.item_priority = PriW'(prio);
    return item;
  endfunction

  // random transaction; narrow priorities half the time to force ties
  function automatic in_item_t random_item(int unsigned insert_pct);
    op_e op;
    op = ($urandom_range(99) < insert_pct) ? OP_INSERT : OP_REMOVE;
    if ($urandom_range(1) == 0) return make_item(op, $urandom, $urandom_range(3));
    return make_item(op, $urandom, $urandom_range(255));
  endfunction

  // present one transaction, with random idle cycles ahead of it
  task automatic send_item(input in_item_t item);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk_i); while (in_stall !== 1'b0);
  endtask

  initial begin : stimulus
    in_item_t    directed[$];
    int unsigned idle_plan[4];
    int unsigned stall_plan[4];
    int unsigned insert_pct;
    idle_plan  = '{0, 50, 0, 9};
    stall_plan = '{0, 0, 50, 9};
    rst_ni     = 1'b0;
    scoreboard = new(CAPACITY);
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // remove from empty, field extremes, ties at head, middle and tail
    directed.push_back(make_item(OP_REMOVE, 16'hFFFF, 8'hFF));
    directed.push_back(make_item(OP_INSERT, 16'hFFFF, 8'hFF));
    directed.push_back(make_item(OP_INSERT, 16'h0000, 8'h00));
    directed.push_back(make_item(OP_INSERT, 16'h1234, 8'h80));
    directed.push_back(make_item(OP_INSERT, 16'h1235, 8'h80));
    directed.push_back(make_item(OP_INSERT, 16'h1236, 8'h80));
    directed.push_back(make_item(OP_INSERT, 16'hAAAA, 8'h00));
    directed.push_back(make_item(OP_INSERT, 16'h5555, 8'hFF));
    directed.push_back(make_item(OP_INSERT, 16'h7F01, 8'h7F));
    repeat (9) directed.push_back(make_item(OP_REMOVE, 16'h0000, 8'h00));
    foreach (directed[i]) send_item(directed[i]);

    // random phases of idling and receiver stall, bursts rotate through filling, draining and balanced mixes
    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct = idle_plan[phase];
      stall_pct     = stall_plan[phase];
      for (int burst = 0; burst < BurstCount; burst++) begin
        case (burst % 3)
          0: begin
            insert_pct = 80;
          end
          1: begin
            insert_pct = 20;
          end
          default: begin
            insert_pct = 50;
          end
        endcase
        repeat (BurstLen) send_item(random_item(insert_pct));
      end
    end
    in_valid <= 1'b0;

    // drain outstanding results, then allow for late extras
    while (scoreboard.pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    if (scoreboard.error_count == 0 && scoreboard.pending_results.size() == 0) begin
      $display("sorted_priority_queue_unit regression: pass");
    end else begin
      $display("sorted_priority_queue_unit regression: fail");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/spq_pkg.sv
hw/rtl/spq_cell.sv
hw/rtl/sorted_priority_queue_unit.sv
test/spq_scoreboard_pkg.sv
test/tb_top.sv
